// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the hash table checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain concurrent assertion, clocked on the rising edge, off during reset.
`define LPHT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same-cycle implication built on the plain form.
`define LPHT_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  `LPHT_ASSERT(lbl, clk, rst, (ante) |-> (cons), msg)

// Next-cycle implication built on the plain form.
`define LPHT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  `LPHT_ASSERT(lbl, clk, rst, (ante) |=> (cons), msg)

`endif

// File: rtl/lpht_pkg.sv
// ---------------------------------------------------------------------------
// lpht_pkg
// Shared sizes, codes and types of the linear probing hash table.
// ---------------------------------------------------------------------------
`default_nettype none

package lpht_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int KEY_W      = 31;
  localparam int VALUE_W    = 32;
  localparam int COUNT_W    = 11;
  localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

  // Home slot is reduced one key byte per cycle.
  localparam int HASH_STEPS = (KEY_W + 7) / 8;
  localparam int HSTEP_W    = (HASH_STEPS > 1) ? $clog2(HASH_STEPS) : 1;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_SEARCH = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_QUERY  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_DONE      = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_LIVE  = 2'd1,
    SLOT_TOMB  = 2'd2
  } slot_state_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_DONE
  } state_t;

  typedef struct packed {
    slot_state_t             state;
    logic [KEY_W-1:0]        key;
    logic [VALUE_W-1:0]      value;
  } slot_word_t;

  localparam int SLOT_WORD_W = $bits(slot_word_t);

endpackage

`default_nettype wire

// File: rtl/lpht_ram.sv
// ---------------------------------------------------------------------------
// lpht_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/lpht_hash.sv
// ---------------------------------------------------------------------------
// lpht_hash
// Home slot unit: key modulo slot count, one key byte per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module lpht_hash (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [lpht_pkg::KEY_W-1:0] key,
  output logic                      done,
  output logic [lpht_pkg::IDX_W-1:0] home
);
  import lpht_pkg::*;

  localparam int KPAD_W = HASH_STEPS * 8;
  localparam int T_W    = IDX_W + 9;
  localparam logic [T_W-1:0] NT = T_W'(SLOT_COUNT);

  // (rem * 256 + byte) mod SLOT_COUNT, with rem already below SLOT_COUNT.
  function automatic logic [IDX_W-1:0] mod_step(input logic [IDX_W-1:0] r,
                                                input logic [7:0] b);
    logic [T_W-1:0] t;
    t = {1'b0, r, b};
    for (int i = 7; i >= 0; i--) begin
      if (t >= (NT << i)) begin
        t = t - (NT << i);
      end
    end
    return t[IDX_W-1:0];
  endfunction

  logic [KPAD_W-1:0]  kbuf;
  logic [IDX_W-1:0]   rem;
  logic [HSTEP_W-1:0] step;
  logic               run;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        step <= '0;
        rem  <= '0;
        kbuf <= KPAD_W'(key);
      end else if (run) begin
        rem  <= mod_step(rem, kbuf[KPAD_W-1 -: 8]);
        kbuf <= kbuf << 8;
        step <= step + 1'b1;
        if (step == HSTEP_W'(HASH_STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign home = rem;

endmodule

`default_nettype wire

// File: rtl/linear_probe_hash_table.sv
// ---------------------------------------------------------------------------
// linear_probe_hash_table: open-addressing key/value table, linear probing.
// Each request word reduces its key in the byte-wide home slot unit, then probes
//   1..SLOT_COUNT slots with one read per cycle of the slot RAM; a status query
//   or an insert into a full table skips both. A new request word is taken
//   only once the last result has been loaded into the output register.
// Reset: synchronous; all slots read empty, count zero, no result pending.
// ---------------------------------------------------------------------------
`default_nettype none

module linear_probe_hash_table (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  action,
  input  logic [lpht_pkg::KEY_W-1:0]   key,
  input  logic [lpht_pkg::VALUE_W-1:0] value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output lpht_pkg::status_t           status,
  output logic                        found,
  output logic [lpht_pkg::VALUE_W-1:0] read_value,
  output logic                        is_empty,
  output logic [lpht_pkg::COUNT_W-1:0] entry_count
);
  import lpht_pkg::*;

  // Sequencer state.
  state_t state, state_next;

  // Request held for the whole probe.
  action_t             act;
  logic [KEY_W-1:0]    req_key;
  logic [VALUE_W-1:0]  req_val;

  // Occupancy. A slot that was never written has its used bit clear and
  // reads as empty, whatever the RAM holds.
  logic [CNT_W-1:0]      live_count, live_next;
  logic [SLOT_COUNT-1:0] used;

  // Probe issue side: one RAM read per cycle, running one slot ahead of
  // the check side. Reads past the stop point are dropped.
  logic [IDX_W-1:0] iss_idx;
  logic [CNT_W-1:0] iss_cnt;
  // Probe check side: the slot whose word arrives this cycle.
  logic             rd_vld;
  logic [IDX_W-1:0] rd_idx;
  logic [CNT_W-1:0] chk_cnt;

  // Probe findings.
  logic               hit;
  logic [IDX_W-1:0]   hit_idx;
  logic [VALUE_W-1:0] hit_val;
  logic               free_vld;
  logic [IDX_W-1:0]   free_idx;

  // Home slot unit.
  logic             hash_start, hash_done;
  logic [IDX_W-1:0] home;

  // RAM ports.
  logic                   ram_re, ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  slot_word_t             ram_wdata, rdata;
  logic [SLOT_WORD_W-1:0] rdata_bits;

  // Check-side decode.
  slot_state_t rd_state;
  logic        slot_hit, slot_free, probe_stop;

  // Result.
  logic               accept, out_free, finish;
  status_t            res_status;
  logic               res_found;
  logic [VALUE_W-1:0] res_value;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign finish   = (state == S_DONE) && out_free;

  lpht_hash u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .key   (key),
    .done  (hash_done),
    .home  (home)
  );

  lpht_ram #(
    .WIDTH (SLOT_WORD_W),
    .DEPTH (SLOT_COUNT)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (iss_idx),
    .rdata (rdata_bits)
  );

  assign rdata = slot_word_t'(rdata_bits);

  // Decode the word that arrived: live match, reusable slot, end of path.
  always_comb begin
    rd_state   = used[rd_idx] ? rdata.state : SLOT_EMPTY;
    slot_hit   = rd_vld && (rd_state == SLOT_LIVE) && (rdata.key == req_key);
    slot_free  = rd_vld && (rd_state != SLOT_LIVE);
    probe_stop = rd_vld && (slot_hit || (rd_state == SLOT_EMPTY) ||
                            (chk_cnt == CNT_W'(SLOT_COUNT - 1)));
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          // Queries and inserts into a full table need no probe.
          if ((action_t'(action) == ACT_QUERY) ||
              ((action_t'(action) == ACT_INSERT) &&
               (live_count >= CNT_W'(SLOT_COUNT)))) begin
            state_next = S_DONE;
          end else begin
            state_next = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (hash_done) begin
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        if (probe_stop) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake, RAM control, result and write-back.
  always_comb begin
    in_ready   = (state == S_IDLE);
    hash_start = accept && (state_next == S_HASH);
    ram_re     = (state == S_PROBE) && (iss_cnt < CNT_W'(SLOT_COUNT));

    ram_we     = 1'b0;
    ram_waddr  = free_idx;
    ram_wdata  = '{state: SLOT_LIVE, key: req_key, value: req_val};
    live_next  = live_count;
    res_status = ST_DONE;
    res_found  = 1'b0;
    res_value  = '0;

    case (act)
      ACT_INSERT: begin
        // A duplicate anywhere on the path wins over a free slot.
        if (hit) begin
          res_status = ST_PRESENT;
        end else if (free_vld) begin
          res_status = ST_INSERTED;
          ram_we     = finish;
          live_next  = live_count + 1'b1;
        end else begin
          res_status = ST_FULL;
        end
      end
      ACT_SEARCH: begin
        if (hit) begin
          res_status = ST_FOUND;
          res_found  = 1'b1;
          res_value  = hit_val;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      ACT_REMOVE: begin
        // Leave a tombstone so later probes walk past this slot.
        if (hit) begin
          res_status = ST_DONE;
          res_found  = 1'b1;
          ram_we     = finish;
          ram_waddr  = hit_idx;
          ram_wdata  = '{state: SLOT_TOMB, key: req_key, value: hit_val};
          live_next  = live_count - 1'b1;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      ACT_QUERY: begin
        res_status = ST_DONE;
      end
      default: res_status = ST_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      live_count <= '0;
      used       <= '0;
      rd_vld     <= 1'b0;
    end else begin
      state <= state_next;

      // Capture the request; clear findings so a short answer sees none.
      if (accept) begin
        act      <= action_t'(action);
        req_key  <= key;
        req_val  <= value;
        hit      <= 1'b0;
        free_vld <= 1'b0;
      end

      // Start the walk at the home slot.
      if ((state == S_HASH) && hash_done) begin
        iss_idx <= home;
        iss_cnt <= '0;
        chk_cnt <= '0;
      end

      if (state == S_PROBE) begin
        // Advance the read pointer, wrapping at the last slot.
        if (ram_re) begin
          iss_idx <= (iss_idx == IDX_W'(SLOT_COUNT - 1)) ? '0 : iss_idx + 1'b1;
          iss_cnt <= iss_cnt + 1'b1;
        end
        rd_vld <= ram_re && !probe_stop;
        rd_idx <= iss_idx;
        if (rd_vld) begin
          chk_cnt <= chk_cnt + 1'b1;
        end
        // Remember the first empty or tombstone slot for an insert.
        if (slot_free && !free_vld) begin
          free_vld <= 1'b1;
          free_idx <= rd_idx;
        end
        if (slot_hit) begin
          hit     <= 1'b1;
          hit_idx <= rd_idx;
          hit_val <= rdata.value;
        end
      end

      // Commit: write back, update the count, load the output register.
      if (finish) begin
        if (ram_we) begin
          used[ram_waddr] <= 1'b1;
        end
        live_count  <= live_next;
        out_valid   <= 1'b1;
        status      <= res_status;
        found       <= res_found;
        read_value  <= res_value;
        is_empty    <= (live_next == '0);
        entry_count <= COUNT_W'(live_next);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/lpht_checker.sv
// ---------------------------------------------------------------------------
// lpht_checker
// Port-level checks of the hash table, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lpht_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [1:0]                  action,
  input logic [lpht_pkg::KEY_W-1:0]   key,
  input logic [lpht_pkg::VALUE_W-1:0] value,
  input logic                        out_valid,
  input logic                        out_ready,
  input lpht_pkg::status_t           status,
  input logic                        found,
  input logic [lpht_pkg::VALUE_W-1:0] read_value,
  input logic                        is_empty,
  input logic [lpht_pkg::COUNT_W-1:0] entry_count
);
  import lpht_pkg::*;

  `LPHT_ASSERT_NEXT(a_in_hold, clk, rst, in_valid && !in_ready,
                    in_valid && $stable(action) && $stable(key) && $stable(value),
                    "request word changed while waiting")
  `LPHT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
                    out_valid && $stable(status) && $stable(read_value) &&
                    $stable(entry_count),
                    "result word changed while stalled")
  `LPHT_ASSERT_IMPL(a_count_range, clk, rst, out_valid,
                    (entry_count <= COUNT_W'(SLOT_COUNT)) &&
                    (is_empty == (entry_count == '0)),
                    "entry count out of range or empty flag mismatch")
  `LPHT_ASSERT_IMPL(a_found_status, clk, rst, out_valid && found,
                    status == ST_FOUND || status == ST_DONE,
                    "found set on a non-matching status")
  `LPHT_ASSERT_IMPL(a_value_zero, clk, rst, out_valid && (status != ST_FOUND),
                    read_value == '0,
                    "read value nonzero without a search hit")

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (.*);

`default_nettype wire

// File: verif/lpht_answer_checker.sv
// ---------------------------------------------------------------------------
// lpht_answer_checker
// Watches both channels of the hash table, keeps a shadow copy of the slot
// array, predicts the answer to every accepted request word and compares it
// field by field with the answer words that the block hands out.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module lpht_answer_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [1:0]                    action,
  input  logic [lpht_pkg::KEY_W-1:0]    key,
  input  logic [lpht_pkg::VALUE_W-1:0]  value,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  lpht_pkg::status_t             status,
  input  logic                          found,
  input  logic [lpht_pkg::VALUE_W-1:0]  read_value,
  input  logic                          is_empty,
  input  logic [lpht_pkg::COUNT_W-1:0]  entry_count,
  output int                            fail_count,
  output int                            answers_owed
);
  import lpht_pkg::*;

  typedef struct packed {
    status_t              status;
    logic                 found;
    logic [VALUE_W-1:0]   read_value;
    logic                 is_empty;
    logic [COUNT_W-1:0]   entry_count;
  } answer_t;

  slot_state_t          shadow_state [SLOT_COUNT];
  logic [KEY_W-1:0]     shadow_key   [SLOT_COUNT];
  logic [VALUE_W-1:0]   shadow_value [SLOT_COUNT];
  int                   live_entries;
  answer_t              pending_answers [$];

  // Apply one request to the shadow table and return the answer it earns.
  function automatic answer_t table_answer(input action_t act,
                                           input logic [KEY_W-1:0] k,
                                           input logic [VALUE_W-1:0] v);
    answer_t ans;
    int      hit;
    int      free_slot;
    int      slot;
    int      n;
    bit      stop;
    ans = '{status: ST_DONE, found: 1'b0, read_value: '0, is_empty: 1'b0,
            entry_count: '0};
    // Walk from home, step over tombstones, halt at the key or a never-used slot.
    hit  = SLOT_COUNT;
    slot = k % SLOT_COUNT;
    stop = 1'b0;
    for (n = 0; n < SLOT_COUNT && !stop; n++) begin
      if (shadow_state[slot] == SLOT_EMPTY) begin
        stop = 1'b1;
      end else if (shadow_state[slot] == SLOT_LIVE && shadow_key[slot] == k) begin
        hit  = slot;
        stop = 1'b1;
      end else begin
        slot = (slot + 1) % SLOT_COUNT;
      end
    end
    case (act)
      ACT_INSERT: begin
        if (live_entries >= SLOT_COUNT) begin
          ans.status = ST_FULL;
        end else if (hit < SLOT_COUNT) begin
          ans.status = ST_PRESENT;
        end else begin
          // First empty slot or tombstone on the path takes the pair.
          free_slot = SLOT_COUNT;
          slot      = k % SLOT_COUNT;
          for (n = 0; n < SLOT_COUNT && free_slot == SLOT_COUNT; n++) begin
            if (shadow_state[slot] != SLOT_LIVE) free_slot = slot;
            else slot = (slot + 1) % SLOT_COUNT;
          end
          if (free_slot < SLOT_COUNT) begin
            shadow_state[free_slot] = SLOT_LIVE;
            shadow_key[free_slot]   = k;
            shadow_value[free_slot] = v;
            live_entries++;
            ans.status = ST_INSERTED;
          end else begin
            ans.status = ST_FULL;
          end
        end
      end
      ACT_SEARCH: begin
        if (hit < SLOT_COUNT) begin
          ans.status     = ST_FOUND;
          ans.found      = 1'b1;
          ans.read_value = shadow_value[hit];
        end else begin
          ans.status = ST_NOT_FOUND;
        end
      end
      ACT_REMOVE: begin
        if (hit < SLOT_COUNT) begin
          shadow_state[hit] = SLOT_TOMB;
          if (live_entries > 0) live_entries--;
          ans.found = 1'b1;
        end else begin
          ans.status = ST_NOT_FOUND;
        end
      end
      default: ans.status = ST_DONE;
    endcase
    ans.is_empty    = (live_entries == 0);
    ans.entry_count = COUNT_W'(live_entries);
    return ans;
  endfunction

  always @(posedge clk) begin : watch
    answer_t want;
    int      errs;
    errs = 0;
    if (rst) begin
      foreach (shadow_state[i]) shadow_state[i] = SLOT_EMPTY;
      live_entries = 0;
      pending_answers.delete();
    end else begin
      // Retire the answer first: no request is answered at its own edge.
      if (out_valid && out_ready) begin
        if (pending_answers.size() == 0) begin
          $error("answer word with no request outstanding");
          errs++;
        end else begin
          want = pending_answers.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            errs++;
          end
          if (found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, found);
            errs++;
          end
          if (read_value !== want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, read_value);
            errs++;
          end
          if (is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, got %0d", want.is_empty, is_empty);
            errs++;
          end
          if (entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   entry_count);
            errs++;
          end
        end
      end
      if (in_valid && in_ready)
        pending_answers.push_back(table_answer(action_t'(action), key, value));
    end
    fail_count   <= fail_count + errs;
    answers_owed <= pending_answers.size();
  end

endmodule

// File: verif/linear_probe_hash_table_tb.sv
// ---------------------------------------------------------------------------
// linear_probe_hash_table_tb
// Drives request words into the hash table: a directed walk through
// collisions, wrap-around, tombstones, duplicates and a full table, then
// random sessions over small key pools that fill and drain the table.
// Both sides idle at random; the checker beside the block judges answers.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module linear_probe_hash_table_tb;
  import lpht_pkg::*;

  localparam int RANDOM_WORDS  = 830;
  localparam int SESSION_WORDS = 60;
  localparam int POOL_SIZE     = 12;
  // Receiver schedule, in cycles after reset: a long hold-off, then a calm
  // stretch where it never stalls.
  localparam int HOLD_FROM     = 3000;
  localparam int HOLD_CYCLES   = 400;
  localparam int CALM_FROM     = 7000;
  localparam int CALM_CYCLES   = 2000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  action_t             action = ACT_QUERY;
  logic [KEY_W-1:0]    key = '0;
  logic [VALUE_W-1:0]  value = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  status_t             status;
  logic                found;
  logic [VALUE_W-1:0]  read_value;
  logic                is_empty;
  logic [COUNT_W-1:0]  entry_count;

  int                  checker_fails;
  int                  answers_owed;
  bit                  sender_gaps = 1'b1;
  logic [KEY_W-1:0]    key_pool [POOL_SIZE];

  always #5 clk = ~clk;

  linear_probe_hash_table uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .key         (key),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .found       (found),
    .read_value  (read_value),
    .is_empty    (is_empty),
    .entry_count (entry_count)
  );

  lpht_answer_checker answer_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .key          (key),
    .value        (value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .found        (found),
    .read_value   (read_value),
    .is_empty     (is_empty),
    .entry_count  (entry_count),
    .fail_count   (checker_fails),
    .answers_owed (answers_owed)
  );

  // Offer one request word. Call at a falling edge; returns at the falling
  // edge after acceptance, with valid still high so the next word can follow
  // without a bubble.
  task automatic send_request(input action_t act, input logic [KEY_W-1:0] k,
                              input logic [VALUE_W-1:0] v);
    while (sender_gaps && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    key      <= k;
    value    <= v;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Receiver: stall at random, except for one long hold-off (the block fills
  // and pushes back on the sender) and one stretch with no stalls at all.
  initial begin : receiver
    int rx_cycle;
    rx_cycle = 0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (rx_cycle >= HOLD_FROM && rx_cycle < HOLD_FROM + HOLD_CYCLES)
        out_ready <= 1'b0;
      else if (rx_cycle >= CALM_FROM && rx_cycle < CALM_FROM + CALM_CYCLES)
        out_ready <= 1'b1;
      else
        out_ready <= ($urandom_range(99) >= 23);
    end
  end

  initial begin : stimulus
    int               item_no;
    int               pick;
    int               ins_w;
    int               rem_w;
    int               n;
    action_t          act;
    logic [KEY_W-1:0] k;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty table: query, miss on search, miss on remove.
    send_request(ACT_QUERY,  '0, 32'hFFFF_FFFF);
    send_request(ACT_SEARCH, '0, '0);
    send_request(ACT_REMOVE, '0, '0);
    // Three keys sharing home slot 0 chain into slots 0, 1, 2.
    send_request(ACT_INSERT, 31'd0,  32'h0000_0000);
    send_request(ACT_INSERT, 31'd8,  32'hFFFF_FFFF);
    send_request(ACT_INSERT, 31'd16, 32'h1234_5678);
    // Tombstone in the middle of the chain: search must step over it, and
    // a re-insert must still see the key behind it as a duplicate.
    send_request(ACT_REMOVE, 31'd8,  '0);
    send_request(ACT_SEARCH, 31'd16, '0);
    send_request(ACT_INSERT, 31'd16, 32'hDEAD_BEEF);
    send_request(ACT_SEARCH, 31'd16, '0);
    send_request(ACT_SEARCH, 31'd8,  '0);
    // Fresh key reuses the tombstone.
    send_request(ACT_INSERT, 31'd24, 32'hA5A5_A5A5);
    // Largest key lands in the last slot; a second key for that slot wraps.
    send_request(ACT_INSERT, 31'h7FFF_FFFF, 32'h8000_0001);
    send_request(ACT_INSERT, 31'd15, 32'h7FFF_FFFE);
    send_request(ACT_SEARCH, 31'd15, '0);
    // Fill the remaining slots, then knock on a full table, including with
    // a key that is present (full check wins over the duplicate check).
    send_request(ACT_INSERT, 31'd4, 32'h5555_5555);
    send_request(ACT_INSERT, 31'd5, 32'hAAAA_AAAA);
    send_request(ACT_INSERT, 31'd6, 32'h0F0F_0F0F);
    send_request(ACT_INSERT, 31'd100, 32'h1111_1111);
    send_request(ACT_INSERT, 31'd0, 32'h2222_2222);
    // Miss in a full table walks every slot.
    send_request(ACT_SEARCH, 31'd99, '0);
    send_request(ACT_QUERY,  31'h7FFF_FFFF, '0);
    send_request(ACT_REMOVE, 31'h7FFF_FFFF, '0);
    send_request(ACT_SEARCH, 31'h7FFF_FFFF, '0);
    send_request(ACT_REMOVE, 31'd15, '0);

    // Random sessions: each draws a fresh key pool with clustered home
    // slots and leans toward filling or draining the table.
    for (item_no = 0; item_no < RANDOM_WORDS; item_no++) begin
      if (item_no % SESSION_WORDS == 0) begin
        foreach (key_pool[i]) begin
          key_pool[i] = KEY_W'($urandom);
          if ($urandom_range(1)) key_pool[i][IDX_W-1:0] = IDX_W'($urandom_range(2));
        end
      end
      if ((item_no / SESSION_WORDS) % 2 == 0) begin
        ins_w = 55;
        rem_w = 15;
      end else begin
        ins_w = 25;
        rem_w = 45;
      end
      // Back-to-back words for a while, no sender idling.
      sender_gaps = !(item_no >= 400 && item_no < 520);
      // Hold the sender until every answer is back.
      if (item_no == 600) begin
        in_valid <= 1'b0;
        wait (answers_owed == 0);
        @(negedge clk);
      end
      pick = $urandom_range(99);
      if (pick < ins_w)                   act = ACT_INSERT;
      else if (pick < ins_w + 25)         act = ACT_SEARCH;
      else if (pick < ins_w + 25 + rem_w) act = ACT_REMOVE;
      else                                act = ACT_QUERY;
      // Mostly pool keys; now and then a stray key the table never saw.
      if ($urandom_range(9) == 0) k = KEY_W'($urandom);
      else k = key_pool[$urandom_range(POOL_SIZE - 1)];
      send_request(act, k, $urandom);
    end

    // Drop valid and drain, then leave room for the longest probe.
    in_valid <= 1'b0;
    for (n = 0; n < 20000 && answers_owed != 0; n++) @(posedge clk);
    repeat (32) @(posedge clk);
    if (answers_owed != 0)
      $error("%0d expected answers never arrived", answers_owed);
    if (checker_fails == 0 && answers_owed == 0)
      $display("linear_probe_hash_table_tb passed");
    else
      $display("linear_probe_hash_table_tb failed");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #3_000_000;
    $display("linear_probe_hash_table_tb failed");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/lpht_pkg.sv
rtl/lpht_ram.sv
rtl/lpht_hash.sv
rtl/linear_probe_hash_table.sv
rtl/lpht_checker.sv
verif/lpht_answer_checker.sv
verif/linear_probe_hash_table_tb.sv
